// File: design/psf_pkg.sv
package psf_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int STORE_PIXELS = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(STORE_PIXELS);
	localparam int TOTAL_W = ADDR_W + 1;
	localparam int DIM_W = 9;

	localparam int RAD_W  = 42;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 3;
	localparam int STEP_W = $clog2(ROOT_W + 1);

	localparam logic [1:0] OP_FADE  = 2'd0;
	localparam logic [1:0] OP_STAMP = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [7:0] FADE_RG = 8'd215;
	localparam logic [7:0] FADE_B  = 8'd225;
	localparam logic [7:0] W_CENTER = 8'd255;
	localparam logic [7:0] W_EDGE   = 8'd90;
	localparam logic [10:0] RED_GAIN = 11'd1225;
	localparam logic [6:0] GREEN_GAIN = 7'd100;
	localparam logic [7:0] GREEN_BASE = 8'd140;
	localparam logic [9:0] BLUE_GAIN = 10'd765;
	localparam logic [27:0] BLUE_BASE = 28'd167116800;
	localparam logic [12:0] RECIP_TEN = 13'd6554;
	localparam logic [3:0] KERNEL_LAST = 4'd9;
	localparam logic [3:0] KERNEL_CENTER = 4'd4;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SQUARE,
		ST_ROOT_GO,
		ST_ROOT,
		ST_WALK,
		ST_RD,
		ST_RDW,
		ST_DONE
	} state_t;

	function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] k);
		logic [15:0] p;
		p = c * k;
		return p[15:8];
	endfunction

	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

endpackage

// File: design/psf_ram.sv
module psf_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [psf_pkg::ADDR_W-1:0]  waddr,
	input  logic [31:0]                 wdata,
	input  logic [psf_pkg::ADDR_W-1:0]  raddr,
	output logic [31:0]                 rdata
);

	logic [31:0] mem [psf_pkg::STORE_PIXELS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/psf_isqrt.sv
module psf_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [psf_pkg::RAD_W-1:0]   radicand,
	output logic                        done,
	output logic                        busy,
	output logic [psf_pkg::ROOT_W-1:0]  root
);

	logic [psf_pkg::RAD_W-1:0]  rad_q;
	logic [psf_pkg::REM_W-1:0]  rem_q;
	logic [psf_pkg::ROOT_W-1:0] root_q;
	logic [psf_pkg::STEP_W-1:0] step_q;
	logic                       run_q;
	logic                       done_q;
	logic [psf_pkg::REM_W-1:0]  rem_n;
	logic [psf_pkg::REM_W-1:0]  trial;
	logic                       take;

	assign rem_n = {rem_q[psf_pkg::REM_W-3:0], rad_q[psf_pkg::RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign take  = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == psf_pkg::STEP_W'(psf_pkg::ROOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[psf_pkg::RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[psf_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[psf_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign busy = run_q;
	assign root = root_q;

endmodule

// File: design/particle_splat_framebuffer_unit.sv
// Particle splat frame store with an RGBA memory of 65536 pixels.
// A command is taken at a clock edge where start is high and busy is low.
// Operation selects fade (whole frame in use), stamp (one particle), read, or (code 3) no action.
// Exactly one result beat follows every command: done is high for one cycle
// with pixel_red/green/blue/alpha (read only) and stamped (stamp only);
// fields that do not apply are zero. The receiver cannot stall the block.
// A drawn stamp waits on the square-root unit, one root bit a cycle, then
// makes 9 pixel reads and writes through the single memory port pair; a fade
// walks the frame, one pixel per cycle through the memory. Busy stays high
// for the whole command. The width and height registers are written through
// cfg_write, cfg_index and cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce; both reset to 256.
// After reset the block clears the store's 65536 pixels, one pixel a cycle,
// with busy high; configuration writes are taken during that pass.
module particle_splat_framebuffer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	output logic                        done,
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [psf_pkg::DIM_W-1:0]   cfg_data,
	input  logic [1:0]                  operation,
	input  logic signed [23:0]          pos_x,
	input  logic signed [23:0]          pos_y,
	input  logic signed [15:0]          vel_x,
	input  logic signed [15:0]          vel_y,
	input  logic [15:0]                 life,
	input  logic [15:0]                 pixel_index,
	output logic [7:0]                  pixel_red,
	output logic [7:0]                  pixel_green,
	output logic [7:0]                  pixel_blue,
	output logic [7:0]                  pixel_alpha,
	output logic                        stamped
);

	psf_pkg::state_t state_q, state_n;

	logic [psf_pkg::DIM_W-1:0]   fw_q, fh_q;
	logic [psf_pkg::DIM_W-1:0]   w_eff, h_eff;
	logic [psf_pkg::TOTAL_W-1:0] total_q, limit_q, cnt_q;
	logic [psf_pkg::ADDR_W-1:0]  addr_q, addr_s1;
	logic [1:0]                  dx_q;
	logic                        valid_s1, center_s1;
	logic [1:0]                  op_q;
	logic signed [23:0]          px_in_q, py_in_q;
	logic signed [15:0]          vx_q, vy_q;
	logic [15:0]                 life_q, idx_q;
	logic [30:0]                 vx2_q, vy2_q;
	logic [25:0]                 life765_q;
	logic [psf_pkg::RAD_W-1:0]   rad_q;
	logic [7:0]                  red_q, green_q, blue_q;
	logic [7:0]                  res_r_q, res_g_q, res_b_q, res_a_q;
	logic                        stamped_q;

	logic signed [15:0]          px, py;
	logic signed [17:0]          wlim, hlim;
	logic                        in_range;
	logic [psf_pkg::ADDR_W-1:0]  base;
	logic [psf_pkg::TOTAL_W-1:0] total_n;
	logic                        issue;
	logic                        mem_we;
	logic [psf_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
	logic [31:0]                 mem_wdata, mem_rdata;
	logic [7:0]                  wt;
	logic                        sq_start, sq_done, sq_busy;
	logic [psf_pkg::ROOT_W-1:0]  sq_root;
	logic [11:0]                 blue_hi;
	logic [24:0]                 blue_prod;
	logic [psf_pkg::ROOT_W-9:0]  red_full;

	psf_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	psf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (rad_q),
		.done     (sq_done),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	assign w_eff = (fw_q > psf_pkg::DIM_W'(psf_pkg::MAX_WIDTH))
		? psf_pkg::DIM_W'(psf_pkg::MAX_WIDTH) : fw_q;
	assign h_eff = (fh_q > psf_pkg::DIM_W'(psf_pkg::MAX_HEIGHT))
		? psf_pkg::DIM_W'(psf_pkg::MAX_HEIGHT) : fh_q;
	assign total_n = psf_pkg::TOTAL_W'(w_eff * h_eff);

	assign px = 16'(px_in_q >>> 8) + {15'd0, px_in_q[23] && (px_in_q[7:0] != 8'd0)};
	assign py = 16'(py_in_q >>> 8) + {15'd0, py_in_q[23] && (py_in_q[7:0] != 8'd0)};
	assign wlim = $signed({9'd0, w_eff}) - 18'sd2;
	assign hlim = $signed({9'd0, h_eff}) - 18'sd2;
	assign in_range = (px >= 16'sd1) && (18'(px) <= wlim)
		&& (py >= 16'sd1) && (18'(py) <= hlim);
	assign base = psf_pkg::ADDR_W'(16'(py - 16'sd1) * w_eff + 16'(px - 16'sd1));

	assign blue_hi   = 12'((psf_pkg::BLUE_BASE - 28'(life765_q)) >> 16);
	assign blue_prod = blue_hi * psf_pkg::RECIP_TEN;
	assign red_full  = sq_root[psf_pkg::ROOT_W-1:8];

	always_comb begin
		state_n = state_q;
		case (state_q)
			psf_pkg::ST_CLEAR: begin
				if (cnt_q[psf_pkg::ADDR_W-1:0] == '1) state_n = psf_pkg::ST_IDLE;
			end
			psf_pkg::ST_IDLE: begin
				if (start) begin
					case (operation)
						psf_pkg::OP_FADE:  state_n = (total_n == '0)
							? psf_pkg::ST_DONE : psf_pkg::ST_WALK;
						psf_pkg::OP_STAMP: state_n = psf_pkg::ST_CHECK;
						psf_pkg::OP_READ:  state_n = psf_pkg::ST_RD;
						default:           state_n = psf_pkg::ST_DONE;
					endcase
				end
			end
			psf_pkg::ST_CHECK:   state_n = in_range ? psf_pkg::ST_SQUARE : psf_pkg::ST_DONE;
			psf_pkg::ST_SQUARE:  state_n = psf_pkg::ST_ROOT_GO;
			psf_pkg::ST_ROOT_GO: state_n = psf_pkg::ST_ROOT;
			psf_pkg::ST_ROOT: begin
				if (sq_done) state_n = psf_pkg::ST_WALK;
			end
			psf_pkg::ST_WALK: begin
				if (cnt_q == limit_q && !valid_s1) state_n = psf_pkg::ST_DONE;
			end
			psf_pkg::ST_RD:   state_n = psf_pkg::ST_RDW;
			psf_pkg::ST_RDW:  state_n = psf_pkg::ST_DONE;
			psf_pkg::ST_DONE: state_n = psf_pkg::ST_IDLE;
			default:          state_n = psf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		issue     = 1'b0;
		sq_start  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_raddr = addr_q;
		mem_wdata = '0;
		wt        = center_s1 ? psf_pkg::W_CENTER : psf_pkg::W_EDGE;
		case (state_q)
			psf_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[psf_pkg::ADDR_W-1:0];
			end
			psf_pkg::ST_ROOT_GO: sq_start = 1'b1;
			psf_pkg::ST_WALK: begin
				issue  = cnt_q != limit_q;
				mem_we = valid_s1;
				if (op_q == psf_pkg::OP_FADE) begin
					mem_wdata = {8'hFF,
						psf_pkg::scale(mem_rdata[23:16], psf_pkg::FADE_B),
						psf_pkg::scale(mem_rdata[15:8], psf_pkg::FADE_RG),
						psf_pkg::scale(mem_rdata[7:0], psf_pkg::FADE_RG)};
				end else begin
					mem_wdata = {8'hFF,
						psf_pkg::sat_add(mem_rdata[23:16], psf_pkg::scale(blue_q, wt)),
						psf_pkg::sat_add(mem_rdata[15:8], psf_pkg::scale(green_q, wt)),
						psf_pkg::sat_add(mem_rdata[7:0], psf_pkg::scale(red_q, wt))};
				end
			end
			psf_pkg::ST_RD: mem_raddr = idx_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= psf_pkg::ST_CLEAR;
			fw_q     <= psf_pkg::DIM_W'(psf_pkg::MAX_WIDTH);
			fh_q     <= psf_pkg::DIM_W'(psf_pkg::MAX_HEIGHT);
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_write) begin
				if (cfg_index == psf_pkg::REG_WIDTH) fw_q <= cfg_data;
				if (cfg_index == psf_pkg::REG_HEIGHT) fh_q <= cfg_data;
			end
			valid_s1 <= issue;
			if (state_q == psf_pkg::ST_CLEAR || issue) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == psf_pkg::ST_IDLE) begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= addr_q;
		center_s1 <= cnt_q[3:0] == psf_pkg::KERNEL_CENTER;
		case (state_q)
			psf_pkg::ST_IDLE: begin
				if (start) begin
					op_q      <= operation;
					px_in_q   <= pos_x;
					py_in_q   <= pos_y;
					vx_q      <= vel_x;
					vy_q      <= vel_y;
					life_q    <= life;
					idx_q     <= pixel_index;
					total_q   <= total_n;
					limit_q   <= total_n;
					addr_q    <= '0;
					dx_q      <= '0;
					res_r_q   <= '0;
					res_g_q   <= '0;
					res_b_q   <= '0;
					res_a_q   <= '0;
					stamped_q <= 1'b0;
				end
			end
			psf_pkg::ST_CHECK: begin
				stamped_q <= in_range;
				vx2_q     <= 31'(32'(vx_q) * 32'(vx_q));
				vy2_q     <= 31'(32'(vy_q) * 32'(vy_q));
				life765_q <= life_q * psf_pkg::BLUE_GAIN;
				addr_q    <= base;
				limit_q   <= psf_pkg::TOTAL_W'(psf_pkg::KERNEL_LAST);
				green_q   <= psf_pkg::GREEN_BASE
					+ 8'(({7'd0, life_q} * psf_pkg::GREEN_GAIN) >> 16);
			end
			psf_pkg::ST_SQUARE: begin
				rad_q  <= ({11'd0, vx2_q} + {11'd0, vy2_q}) * psf_pkg::RED_GAIN;
				blue_q <= blue_prod[23:16];
			end
			psf_pkg::ST_ROOT: begin
				if (sq_done) begin
					red_q <= (red_full > 13'd255) ? 8'hFF : red_full[7:0];
				end
			end
			psf_pkg::ST_WALK: begin
				if (issue) begin
					if (op_q == psf_pkg::OP_STAMP && dx_q == 2'd2) begin
						addr_q <= psf_pkg::ADDR_W'(addr_q + w_eff - 2'd2);
						dx_q   <= '0;
					end else begin
						addr_q <= addr_q + 1'b1;
						dx_q   <= dx_q + 1'b1;
					end
				end
			end
			psf_pkg::ST_RDW: begin
				if (psf_pkg::TOTAL_W'(idx_q) < total_q) begin
					res_r_q <= mem_rdata[7:0];
					res_g_q <= mem_rdata[15:8];
					res_b_q <= mem_rdata[23:16];
					res_a_q <= mem_rdata[31:24];
				end
			end
			default: ;
		endcase
	end

	assign busy        = state_q != psf_pkg::ST_IDLE;
	assign done        = state_q == psf_pkg::ST_DONE;
	assign pixel_red   = done ? res_r_q : 8'd0;
	assign pixel_green = done ? res_g_q : 8'd0;
	assign pixel_blue  = done ? res_b_q : 8'd0;
	assign pixel_alpha = done ? res_a_q : 8'd0;
	assign stamped     = done & stamped_q;

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block still busy after its result beat");

	a_root_only_in_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		sq_busy |-> state_q == psf_pkg::ST_ROOT)
		else $error("square-root unit running outside a stamp");

	a_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == psf_pkg::ST_WALK || state_q == psf_pkg::ST_CLEAR))
		else $error("frame store written outside a walk or clear");

	a_stamp_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psf_pkg::ST_WALK && op_q == psf_pkg::OP_STAMP)
		|-> cnt_q <= psf_pkg::TOTAL_W'(psf_pkg::KERNEL_LAST))
		else $error("stamp walked past its kernel");

endmodule
